/* rtl/core/rth_pkg.sv */
`default_nettype none

package rth_pkg;

	// Request function codes.
	localparam logic [1:0] FUNC_RESTART = 2'd0;
	localparam logic [1:0] FUNC_SCAN    = 2'd1;
	localparam logic [1:0] FUNC_BIN     = 2'd2;
	localparam logic [1:0] FUNC_READ    = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_CLAMP = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
	localparam logic [31:0]        COUNT_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] sample;
		logic [9:0]         bin_index;
	} rth_req_t;

	typedef struct packed {
		logic [31:0]        count_value;
		logic signed [31:0] low_seen;
		logic signed [31:0] high_seen;
		logic [9:0]         bin_chosen;
		logic [1:0]         status;
	} rth_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/range_tracking_histogram.sv */
`default_nettype none

// Equal-width histogram over signed Q16.16 samples with a running min/max range.
// A request is taken when start is high and busy is low. Exactly one result
// follows per request: rsp is valid for the single cycle in which done is high,
// and the receiver has no way to hold it off.
// Restart and scan requests, and reads of a bin at or beyond BINS, never leave idle:
// done rises the cycle after the request and busy stays low.
// A read of an existing bin goes through a memory read, then a write-back of zero.
// A bin request with an empty range or a sample outside it skips to read and write-back.
// A bin request inside the range runs one subtract stage, one multiply by BINS,
// QW steps of the shared compare-and-subtract unit of a restoring divider, with
// QW = clog2(BINS+1), then the bin clamp, the memory read and the write-back.
// Otherwise busy is high until done rises; the next one may start the cycle done rises.
// After reset the block sweeps the bin memory to zero, one bin per cycle, and
// holds busy high until the last bin is cleared, before the first request is taken.
// Reset also returns the tracked range to empty (min at the most positive value,
// max at the most negative value).
module range_tracking_histogram #(
	parameter int BINS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rth_pkg::rth_req_t req,
	output logic              done,
	output rth_pkg::rth_rsp_t rsp
);
	import rth_pkg::*;

	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int QW = $clog2(BINS + 1);
	localparam int CW = $clog2(QW);
	localparam int NW = 32 + QW;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PREP = 4'd2;
	localparam logic [3:0] S_SUB  = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_BIN  = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_WR   = 4'd8;

	logic [3:0]         state_q;
	logic               done_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      cnt_q;
	logic signed [31:0] low_q;
	logic signed [31:0] high_q;

	logic [1:0]         func_q;
	logic signed [31:0] x_q;
	logic [9:0]         idx_q;
	logic [AW-1:0]      addr_q;
	logic [1:0]         st_q;
	logic [31:0]        d_q;
	logic [31:0]        r_q;
	logic [31:0]        rem_q;
	logic [QW-1:0]      nlo_q;
	logic [QW-1:0]      quo_q;
	logic [31:0]        mem_rd_q;
	rth_rsp_t           rsp_q;

	logic [31:0]        mem [BINS];

	logic               accept;
	logic               idx_ok;
	logic signed [31:0] scan_low;
	logic signed [31:0] scan_high;
	logic [NW-1:0]      prod;
	logic [32:0]        div_try;
	logic [32:0]        div_diff;
	logic               div_ge;
	logic [QW-1:0]      quo_next;
	logic               cnt_sat;
	logic [31:0]        cnt_inc;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [31:0]        mem_wd;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign idx_ok = ({22'd0, req.bin_index} < 32'(BINS));

	always_comb begin
		scan_low  = (req.sample < low_q) ? req.sample : low_q;
		scan_high = (req.sample > high_q) ? req.sample : high_q;
	end

	assign prod = NW'(d_q) * NW'(BINS);

	// One restoring-division step: shift in the next numerator bit and try r.
	always_comb begin
		div_try  = {rem_q, nlo_q[QW-1]};
		div_diff = div_try - {1'b0, r_q};
		div_ge   = (div_try >= {1'b0, r_q});
		quo_next = {quo_q[QW-2:0], div_ge};
	end

	assign cnt_sat = (mem_rd_q == COUNT_MAX);
	assign cnt_inc = cnt_sat ? mem_rd_q : (mem_rd_q + 32'd1);

	always_comb begin
		mem_we = (state_q == S_CLR) || (state_q == S_WR);
		mem_wa = (state_q == S_CLR) ? clr_q : addr_q;
		if (state_q == S_WR && func_q == FUNC_BIN) begin
			mem_wd = cnt_inc;
		end else begin
			mem_wd = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_RD) begin
			mem_rd_q <= mem[addr_q];
		end
	end

	// Sequencer and range registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done_q  <= 1'b0;
			clr_q   <= '0;
			cnt_q   <= '0;
			low_q   <= SAMPLE_MAX;
			high_q  <= SAMPLE_MIN;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(BINS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (req.func)
							FUNC_RESTART: begin
								low_q  <= SAMPLE_MAX;
								high_q <= SAMPLE_MIN;
								done_q <= 1'b1;
							end
							FUNC_SCAN: begin
								low_q  <= scan_low;
								high_q <= scan_high;
								done_q <= 1'b1;
							end
							FUNC_BIN: begin
								state_q <= S_PREP;
							end
							FUNC_READ: begin
								if (idx_ok) begin
									state_q <= S_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_PREP: begin
					if (high_q <= low_q || x_q < low_q || x_q > high_q) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q   <= CW'(QW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= S_BIN;
					end
				end
				S_BIN: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q <= req.func;
					x_q    <= req.sample;
					idx_q  <= req.bin_index;
					addr_q <= AW'(req.bin_index);
					rsp_q.count_value <= 32'd0;
					rsp_q.bin_chosen  <= req.bin_index;
					rsp_q.status      <= ST_OK;
					if (req.func == FUNC_RESTART) begin
						rsp_q.low_seen  <= SAMPLE_MAX;
						rsp_q.high_seen <= SAMPLE_MIN;
					end else if (req.func == FUNC_SCAN) begin
						rsp_q.low_seen  <= scan_low;
						rsp_q.high_seen <= scan_high;
					end else begin
						rsp_q.low_seen  <= low_q;
						rsp_q.high_seen <= high_q;
					end
				end
			end
			S_PREP: begin
				// Empty range, then below, then above, in that order of precedence.
				if (high_q <= low_q) begin
					st_q   <= ST_EMPTY;
					addr_q <= '0;
				end else if (x_q < low_q) begin
					st_q   <= ST_CLAMP;
					addr_q <= '0;
				end else if (x_q > high_q) begin
					st_q   <= ST_CLAMP;
					addr_q <= AW'(BINS - 1);
				end else begin
					st_q <= ST_OK;
				end
			end
			S_SUB: begin
				d_q <= 32'(x_q - low_q);
				r_q <= 32'(high_q - low_q);
			end
			S_MUL: begin
				// The high part of d*BINS is always below r, so only QW steps remain.
				rem_q <= prod[NW-1:QW];
				nlo_q <= prod[QW-1:0];
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? div_diff[31:0] : div_try[31:0];
				nlo_q <= {nlo_q[QW-2:0], 1'b0};
				quo_q <= quo_next;
			end
			S_BIN: begin
				// A sample equal to the maximum lands one past the last bin.
				if (quo_q >= QW'(BINS)) begin
					addr_q <= AW'(BINS - 1);
				end else begin
					addr_q <= AW'(quo_q);
				end
			end
			S_WR: begin
				if (func_q == FUNC_BIN) begin
					rsp_q.count_value <= cnt_inc;
					rsp_q.bin_chosen  <= 10'(addr_q);
					rsp_q.status      <= cnt_sat ? ST_SAT : st_q;
				end else begin
					rsp_q.count_value <= mem_rd_q;
					rsp_q.bin_chosen  <= idx_q;
					rsp_q.status      <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while a request is still in progress");

	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |=> done_q)
		else $error("write-back not followed by a result");

	a_bin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FUNC_BIN) |=> busy)
		else $error("bin request did not start the sequencer");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (r_q != 32'd0 && rem_q < r_q))
		else $error("divider entered with a zero range or an oversized remainder");

	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !done_q)
		else $error("result strobe during the clearing sweep");

endmodule

`default_nettype wire

/* sim/range_tracking_histogram_tb.sv */
`timescale 1ns / 100ps

module range_tracking_histogram_tb;
	import rth_pkg::*;

	localparam int NBINS        = 1024;
	localparam int RANDOM_ITEMS = 1225;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 40;

	// Q16.16 constants used by the directed tests.
	localparam logic signed [31:0] MINUS_THREE = -32'sd196608;
	localparam logic signed [31:0] SEVEN_QTR   = 32'sd475136;
	localparam logic signed [31:0] FIVE        = 32'sd327680;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	rth_req_t req    = '0;
	logic     busy;
	logic     done;
	rth_rsp_t rsp;

	// Shadow copy of the histogram state.
	logic [31:0]        bin_count [NBINS];
	logic signed [31:0] trk_low;
	logic signed [31:0] trk_high;

	rth_rsp_t    pending_results [$];
	rth_rsp_t    exp_rsp;
	int          fail_count  = 0;
	int          burst_left  = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	range_tracking_histogram #(
		.BINS(NBINS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	function automatic rth_rsp_t next_histogram_result(rth_req_t r);
		rth_rsp_t res;
		longint   lo;
		longint   hi;
		longint   xs;
		longint   b;
		res = '0;
		res.bin_chosen = r.bin_index;
		res.status = ST_OK;
		case (r.func)
			FUNC_RESTART: begin
				trk_low = SAMPLE_MAX;
				trk_high = SAMPLE_MIN;
			end
			FUNC_SCAN: begin
				if ($signed(r.sample) > trk_high)
					trk_high = r.sample;
				if ($signed(r.sample) < trk_low)
					trk_low = r.sample;
			end
			FUNC_BIN: begin
				lo = trk_low;
				hi = trk_high;
				xs = $signed(r.sample);
				if (hi <= lo) begin
					b = 0;
					res.status = ST_EMPTY;
				end else if (xs < lo) begin
					b = 0;
					res.status = ST_CLAMP;
				end else if (xs > hi) begin
					b = NBINS - 1;
					res.status = ST_CLAMP;
				end else begin
					// Exact integer bin; the top of the range lands one past the end.
					b = ((xs - lo) * NBINS) / (hi - lo);
					if (b >= NBINS)
						b = NBINS - 1;
				end
				if (bin_count[b] == COUNT_MAX)
					res.status = ST_SAT;
				else
					bin_count[b] = bin_count[b] + 1;
				res.count_value = bin_count[b];
				res.bin_chosen = b[9:0];
			end
			FUNC_READ: begin
				if (int'(r.bin_index) < NBINS) begin
					res.count_value = bin_count[r.bin_index];
					bin_count[r.bin_index] = '0;
				end
			end
		endcase
		res.low_seen = trk_low;
		res.high_seen = trk_high;
		return res;
	endfunction

	// Issues one request with bursty pacing and records its expected result
	// at the edge where it is taken.
	task automatic send_request(input logic [1:0] f, input logic [31:0] s,
			input logic [9:0] idx);
		rth_req_t r;
		int       gap;
		r.func = f;
		r.sample = s;
		r.bin_index = idx;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end else begin
			burst_left--;
		end
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(next_histogram_result(r));
	endtask

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with no pending request, actual %p", $time, rsp);
			end else begin
				exp_rsp = pending_results.pop_front();
				if (rsp.count_value !== exp_rsp.count_value)
					report_field("count_value", exp_rsp.count_value, rsp.count_value);
				if (rsp.low_seen !== exp_rsp.low_seen)
					report_field("low_seen", exp_rsp.low_seen, rsp.low_seen);
				if (rsp.high_seen !== exp_rsp.high_seen)
					report_field("high_seen", exp_rsp.high_seen, rsp.high_seen);
				if (rsp.bin_chosen !== exp_rsp.bin_chosen)
					report_field("bin_chosen", 32'(exp_rsp.bin_chosen), 32'(rsp.bin_chosen));
				if (rsp.status !== exp_rsp.status)
					report_field("status", 32'(exp_rsp.status), 32'(rsp.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Nothing scanned yet, then a single scanned value: both are empty ranges.
	task automatic test_empty_range;
		send_request(FUNC_BIN, 32'sd0, 10'h155);
		send_request(FUNC_BIN, SAMPLE_MAX, 10'h2AA);
		send_request(FUNC_READ, 32'hFFFF_FFFF, 10'd0);
		send_request(FUNC_SCAN, FIVE, 10'h3FF);
		send_request(FUNC_BIN, FIVE, 10'd0);
	endtask

	// Full-scale range: both sample extremes, the midpoint and just below it.
	task automatic test_full_scale;
		send_request(FUNC_SCAN, SAMPLE_MIN, 10'd0);
		send_request(FUNC_SCAN, SAMPLE_MAX, 10'h3FF);
		send_request(FUNC_BIN, SAMPLE_MIN, 10'd0);
		send_request(FUNC_BIN, SAMPLE_MAX, 10'd0);
		send_request(FUNC_BIN, 32'sd0, 10'd0);
		send_request(FUNC_BIN, -32'sd1, 10'd0);
		send_request(FUNC_READ, 32'd0, 10'h3FF);
		send_request(FUNC_READ, 32'd0, 10'd511);
	endtask

	// Narrow range after a restart: samples below, above, at the top and at
	// the bottom; counts from before the restart must survive it.
	task automatic test_clamp_and_restart;
		send_request(FUNC_RESTART, 32'h5A5A_5A5A, 10'h3FF);
		send_request(FUNC_SCAN, MINUS_THREE, 10'd0);
		send_request(FUNC_SCAN, SEVEN_QTR, 10'd0);
		send_request(FUNC_BIN, MINUS_THREE - 1, 10'd0);
		send_request(FUNC_BIN, SEVEN_QTR + 1, 10'd0);
		send_request(FUNC_BIN, SEVEN_QTR, 10'd0);
		send_request(FUNC_BIN, MINUS_THREE, 10'd0);
		send_request(FUNC_READ, 32'd0, 10'd0);
		send_request(FUNC_READ, 32'd0, 10'h3FF);
		send_request(FUNC_READ, 32'd0, 10'd512);
	endtask

	// Mostly well-formed traffic: new ranges scanned in, then samples binned
	// in and around them, with reads that often hit recently used bins.
	task automatic test_random_traffic;
		int                 sent;
		int                 roll;
		int                 n;
		int                 sel;
		logic [31:0]        centre;
		logic [31:0]        mask;
		logic [31:0]        s;
		logic [9:0]         last_bin;
		longint             span;
		sent = 0;
		last_bin = '0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_request(2'($urandom), $urandom, 10'($urandom));
				sent++;
			end else if (roll < 20) begin
				send_request(FUNC_RESTART, $urandom, 10'($urandom));
				sent++;
				n = $urandom_range(1, 5);
				centre = $urandom;
				mask = 32'hFFFF_FFFF >> $urandom_range(0, 31);
				repeat (n) begin
					send_request(FUNC_SCAN, centre + ($urandom & mask), 10'($urandom));
					sent++;
				end
			end else if (roll < 28) begin
				send_request(FUNC_SCAN, trk_high + $urandom_range(0, 65536), 10'($urandom));
				sent++;
			end else if (roll < 80) begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					span = longint'(trk_high) - longint'(trk_low);
					sel = $urandom_range(0, 9);
					if (span <= 0)
						s = $urandom;
					else if (sel == 0)
						s = trk_low;
					else if (sel == 1)
						s = trk_high;
					else if (sel == 2)
						s = 32'(longint'(trk_low) - 1 - $urandom_range(0, 1000));
					else if (sel == 3)
						s = 32'(longint'(trk_high) + 1 + $urandom_range(0, 1000));
					else
						s = 32'(longint'(trk_low) + longint'($urandom) % (span + 1));
					send_request(FUNC_BIN, s, 10'($urandom));
					last_bin = pending_results[$].bin_chosen;
					sent++;
				end
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					send_request(FUNC_READ, $urandom,
						($urandom_range(0, 1) == 1) ? last_bin : 10'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NBINS; i++)
			bin_count[i] = '0;
		trk_low = SAMPLE_MAX;
		trk_high = SAMPLE_MIN;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_range();
		test_full_scale();
		test_clamp_and_restart();
		test_random_traffic();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
